// File: design/tqb_pkg.sv
`timescale 1ns / 1ps
package tqb_pkg;

  localparam int MAX_QUADS   = 16384;
  localparam int TEX_SLOTS   = 32;
  localparam int TEX_ID_BITS = 16;

  localparam int QCNT_W = $clog2(MAX_QUADS + 1);
  localparam int SCNT_W = $clog2(TEX_SLOTS + 1);
  localparam int SIDX_W = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;

  // quarter-wave sine polynomial coefficients
  localparam logic [32:0] POLY_C1 = 33'd421657428;
  localparam logic [32:0] POLY_C3 = 33'd173399668;
  localparam logic [32:0] POLY_C5 = 33'd20177696;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLUSH,
    ST_CHKMAX,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_MISS,
    ST_T2,
    ST_C5,
    ST_C3,
    ST_C1,
    ST_RND,
    ST_SXC,
    ST_SYS,
    ST_SXS,
    ST_SYC,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_T2,
    MOP_C5,
    MOP_C3,
    MOP_C1,
    MOP_SXC,
    MOP_SYS,
    MOP_SXS,
    MOP_SYC
  } mop_e;

  typedef struct packed {
    logic ld_in;
    logic clr_batch;
    logic emit_flush;
    logic emit_vtx;
    logic last;
    logic srch_clr;
    logic srch_rd;
    logic srch_inc;
    logic set_hit;
    logic alloc;
    mop_e mop;
    logic phase;      // 0 cosine pass, 1 sine pass
    logic store_trig;
    logic corner_clr;
    logic corner_inc;
    logic quad_inc;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic q_full;
    logic q_nz;
    logic slots_full;
    logic srch_end;
    logic hit;
    logic out_free;
    logic corner_last;
  } sts_t;

endpackage

// File: design/tqb_ctrl.sv
`timescale 1ns / 1ps
module tqb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tqb_pkg::sts_t sts_i,
  output tqb_pkg::cmd_t cmd_o
);
  import tqb_pkg::*;

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mop  = MOP_NONE;
    cmd_o.phase = phase_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = sts_i.action ? ST_FLUSH : ST_CHKMAX;
      end
      ST_FLUSH: begin
        if (!sts_i.q_nz) begin
          cmd_o.clr_batch = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          cmd_o.last = 1'b1;
          cmd_o.clr_batch = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CHKMAX: begin
        if (!sts_i.q_full) begin
          cmd_o.srch_clr = 1'b1;
          state_d = ST_SRCH_RD;
        end else if (sts_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          cmd_o.clr_batch = 1'b1;
          cmd_o.srch_clr = 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (sts_i.srch_end) begin
          state_d = ST_MISS;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (sts_i.hit) begin
          cmd_o.set_hit = 1'b1;
          phase_d = 1'b0;
          state_d = ST_T2;
        end else begin
          cmd_o.srch_inc = 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_MISS: begin
        // close a full batch first, then take the next free slot
        if (sts_i.slots_full) begin
          if (!sts_i.q_nz) begin
            cmd_o.clr_batch = 1'b1;
          end else if (sts_i.out_free) begin
            cmd_o.emit_flush = 1'b1;
            cmd_o.clr_batch = 1'b1;
          end
        end else begin
          cmd_o.alloc = 1'b1;
          phase_d = 1'b0;
          state_d = ST_T2;
        end
      end
      ST_T2: begin
        cmd_o.mop = MOP_T2;
        state_d = ST_C5;
      end
      ST_C5: begin
        cmd_o.mop = MOP_C5;
        state_d = ST_C3;
      end
      ST_C3: begin
        cmd_o.mop = MOP_C3;
        state_d = ST_C1;
      end
      ST_C1: begin
        cmd_o.mop = MOP_C1;
        state_d = ST_RND;
      end
      ST_RND: begin
        cmd_o.store_trig = 1'b1;
        if (!phase_q) begin
          phase_d = 1'b1;
          state_d = ST_T2;
        end else begin
          state_d = ST_SXC;
        end
      end
      ST_SXC: begin
        cmd_o.mop = MOP_SXC;
        cmd_o.corner_clr = 1'b1;
        state_d = ST_SYS;
      end
      ST_SYS: begin
        cmd_o.mop = MOP_SYS;
        state_d = ST_SXS;
      end
      ST_SXS: begin
        cmd_o.mop = MOP_SXS;
        state_d = ST_SYC;
      end
      ST_SYC: begin
        cmd_o.mop = MOP_SYC;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_vtx = 1'b1;
          cmd_o.last = sts_i.corner_last;
          cmd_o.corner_inc = 1'b1;
          if (sts_i.corner_last) begin
            cmd_o.quad_inc = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/tqb_dp.sv
`timescale 1ns / 1ps
module tqb_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tqb_pkg::cmd_t       cmd_i,
  output tqb_pkg::sts_t       sts_o,
  input  logic                action_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [31:0]  size_x_i,
  input  logic signed [31:0]  size_y_i,
  input  logic        [15:0]  angle_i,
  input  logic        [15:0]  texture_id_i,
  input  logic        [15:0]  tiling_i,
  input  logic        [31:0]  rgba_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic signed [31:0]  vert_x_o,
  output logic signed [31:0]  vert_y_o,
  output logic signed [31:0]  vert_z_o,
  output logic        [31:0]  vert_rgba_o,
  output logic                tex_u_o,
  output logic                tex_v_o,
  output logic        [5:0]   slot_o,
  output logic        [15:0]  vert_tiling_o,
  output logic        [14:0]  batch_quads_o,
  output logic                last_o
);
  import tqb_pkg::*;

  // input word
  logic                   action_q;
  logic signed [31:0]     px_q, py_q, pz_q, sx_q, sy_q;
  logic [15:0]            angle_q, tiling_q;
  logic [TEX_ID_BITS-1:0] id_q;
  logic [31:0]            rgba_q;

  // batch state
  logic [QCNT_W-1:0]      quads_q;
  logic [SCNT_W-1:0]      slots_q;
  logic [SCNT_W-1:0]      idx_q;
  logic [SCNT_W-1:0]      slot_q;
  logic [TEX_ID_BITS-1:0] table_mem [TEX_SLOTS];
  logic [TEX_ID_BITS-1:0] rd_q;
  logic [1:0]             corner_q;

  // arithmetic
  logic [28:0]            t2_q;
  logic [56:0]            m_q;
  logic signed [16:0]     cos_q, sin_q;
  logic signed [47:0]     p_sxc_q, p_sys_q, p_sxs_q, p_syc_q;

  // output register
  logic                   ovalid_q;

  logic                   out_free;
  assign out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      action_q <= action_i;
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      pz_q     <= pos_z_i;
      sx_q     <= size_x_i;
      sy_q     <= size_y_i;
      angle_q  <= angle_i;
      id_q     <= TEX_ID_BITS'(texture_id_i);
      tiling_q <= tiling_i;
      rgba_q   <= rgba_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quads_q <= '0;
      slots_q <= '0;
    end else begin
      if (cmd_i.clr_batch) begin
        quads_q <= '0;
        slots_q <= '0;
      end else begin
        if (cmd_i.alloc) slots_q <= slots_q + 1'b1;
        if (cmd_i.quad_inc) quads_q <= quads_q + 1'b1;
      end
    end
  end

  // slot table and search
  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_rd) rd_q <= table_mem[idx_q[SIDX_W-1:0]];
    if (cmd_i.alloc) table_mem[slots_q[SIDX_W-1:0]] <= id_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_clr) idx_q <= '0;
    else if (cmd_i.srch_inc) idx_q <= idx_q + 1'b1;
    if (cmd_i.set_hit) slot_q <= idx_q;
    else if (cmd_i.alloc) slot_q <= slots_q;
    if (cmd_i.corner_clr) corner_q <= '0;
    else if (cmd_i.corner_inc) corner_q <= corner_q + 1'b1;
  end

  // quarter-wave argument for the current pass
  logic [15:0] a_eff;
  logic [14:0] t;
  assign a_eff = cmd_i.phase ? angle_q : angle_q + 16'd16384;
  assign t = a_eff[14] ? (15'd16384 - {1'b0, a_eff[13:0]}) : {1'b0, a_eff[13:0]};

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mop)
      MOP_T2: begin
        mul_a = $signed({18'd0, t});
        mul_b = $signed({18'd0, t});
      end
      MOP_C5: begin
        mul_a = $signed(POLY_C5);
        mul_b = $signed({4'd0, t2_q});
      end
      MOP_C3: begin
        mul_a = $signed(POLY_C3 - {4'd0, m_q[56:28]});
        mul_b = $signed({4'd0, t2_q});
      end
      MOP_C1: begin
        mul_a = $signed(POLY_C1 - {4'd0, m_q[56:28]});
        mul_b = $signed({18'd0, t});
      end
      MOP_SXC: begin
        mul_a = {sx_q[31], sx_q};
        mul_b = {{16{cos_q[16]}}, cos_q};
      end
      MOP_SYS: begin
        mul_a = {sy_q[31], sy_q};
        mul_b = {{16{sin_q[16]}}, sin_q};
      end
      MOP_SXS: begin
        mul_a = {sx_q[31], sx_q};
        mul_b = {{16{sin_q[16]}}, sin_q};
      end
      MOP_SYC: begin
        mul_a = {sy_q[31], sy_q};
        mul_b = {{16{cos_q[16]}}, cos_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    case (cmd_i.mop)
      MOP_T2:  t2_q    <= prod[28:0];
      MOP_C5:  m_q     <= prod[56:0];
      MOP_C3:  m_q     <= prod[56:0];
      MOP_C1:  m_q     <= prod[56:0];
      MOP_SXC: p_sxc_q <= prod[47:0];
      MOP_SYS: p_sys_q <= prod[47:0];
      MOP_SXS: p_sxs_q <= prod[47:0];
      MOP_SYC: p_syc_q <= prod[47:0];
      default: begin
      end
    endcase
  end

  // round to Q15, saturate, apply quadrant sign
  logic [43:0]        v_rnd;
  logic [15:0]        v_mag;
  logic signed [16:0] v_sgn;
  assign v_rnd = {1'b0, m_q[56:14]} + 44'd4096;
  assign v_mag = (v_rnd[43:13] > 31'd32767) ? 16'd32767 : v_rnd[28:13];
  assign v_sgn = a_eff[15] ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_trig) begin
      if (angle_q == 16'd0) begin
        // no rotation: exact unit cosine
        cos_q <= 17'sd32768;
        sin_q <= '0;
      end else if (cmd_i.phase) begin
        sin_q <= v_sgn;
      end else begin
        cos_q <= v_sgn;
      end
    end
  end

  // corner offsets
  logic               cx_pos, cy_pos;
  logic signed [49:0] dx, dy, dx_r, dy_r;
  logic signed [49:0] a_x, b_x, a_y, b_y;
  assign cx_pos = (corner_q == 2'd1) || (corner_q == 2'd2);
  assign cy_pos = corner_q[1];
  assign a_x = cx_pos ? 50'(p_sxc_q) : -50'(p_sxc_q);
  assign b_x = cy_pos ? 50'(p_sys_q) : -50'(p_sys_q);
  assign a_y = cx_pos ? 50'(p_sxs_q) : -50'(p_sxs_q);
  assign b_y = cy_pos ? 50'(p_syc_q) : -50'(p_syc_q);
  assign dx = a_x - b_x;
  assign dy = a_y + b_y;
  assign dx_r = (dx + 50'sd32768) >>> 16;
  assign dy_r = (dy + 50'sd32768) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_flush || cmd_i.emit_vtx) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_flush) begin
      kind_o        <= 1'b1;
      vert_x_o      <= '0;
      vert_y_o      <= '0;
      vert_z_o      <= '0;
      vert_rgba_o   <= '0;
      tex_u_o       <= 1'b0;
      tex_v_o       <= 1'b0;
      slot_o        <= 6'(slots_q);
      vert_tiling_o <= '0;
      batch_quads_o <= 15'(quads_q);
      last_o        <= cmd_i.last;
    end else if (cmd_i.emit_vtx) begin
      kind_o        <= 1'b0;
      vert_x_o      <= px_q + dx_r[31:0];
      vert_y_o      <= py_q + dy_r[31:0];
      vert_z_o      <= pz_q;
      vert_rgba_o   <= rgba_q;
      tex_u_o       <= cx_pos;
      tex_v_o       <= cy_pos;
      slot_o        <= 6'(slot_q);
      vert_tiling_o <= tiling_q;
      batch_quads_o <= '0;
      last_o        <= cmd_i.last;
    end
  end

  assign out_valid_o = ovalid_q;

  always_comb begin
    sts_o.action      = action_q;
    sts_o.q_full      = quads_q >= QCNT_W'(MAX_QUADS);
    sts_o.q_nz        = quads_q != '0;
    sts_o.slots_full  = slots_q >= SCNT_W'(TEX_SLOTS);
    sts_o.srch_end    = idx_q >= slots_q;
    sts_o.hit         = rd_q == id_q;
    sts_o.out_free    = out_free;
    sts_o.corner_last = corner_q == 2'd3;
  end

endmodule

// File: design/textured_quad_batcher.sv
`timescale 1ns / 1ps
// A draw searches the texture table slot by slot (a read, then a compare, per slot; one read
// port), takes the next free slot on a miss (closing the batch first when all slots are
// taken), then works out cosine, sine and the corner products; output stalls can hold it.
// Throughput: one item at a time; trig and corner products share one multiplier
// (ten steps for sine and cosine, four for the products), then one vertex per cycle
// while the output is not stalled. Reset is asynchronous, active low, and empties
// the batch; the slot table holds no reset value and is only read below the fill count.
module textured_quad_batcher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] size_x_i,
  input  logic signed [31:0] size_y_i,
  input  logic        [15:0] angle_i,
  input  logic        [15:0] texture_id_i,
  input  logic        [15:0] tiling_i,
  input  logic        [31:0] rgba_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic signed [31:0] vert_z_o,
  output logic        [31:0] vert_rgba_o,
  output logic               tex_u_o,
  output logic               tex_v_o,
  output logic        [5:0]  slot_o,
  output logic        [15:0] vert_tiling_o,
  output logic        [14:0] batch_quads_o,
  output logic               last_o
);
  import tqb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tqb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tqb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .size_x_i      (size_x_i),
    .size_y_i      (size_y_i),
    .angle_i       (angle_i),
    .texture_id_i  (texture_id_i),
    .tiling_i      (tiling_i),
    .rgba_i        (rgba_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .vert_x_o      (vert_x_o),
    .vert_y_o      (vert_y_o),
    .vert_z_o      (vert_z_o),
    .vert_rgba_o   (vert_rgba_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .slot_o        (slot_o),
    .vert_tiling_o (vert_tiling_o),
    .batch_quads_o (batch_quads_o),
    .last_o        (last_o)
  );

endmodule

// File: sim/tqb_vertex_check.sv
`timescale 1ns / 1ps
module tqb_vertex_check
  import tqb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               action_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] size_x_i,
  input  logic signed [31:0] size_y_i,
  input  logic        [15:0] angle_i,
  input  logic        [15:0] texture_id_i,
  input  logic        [15:0] tiling_i,
  input  logic        [31:0] rgba_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               kind_i,
  input  logic signed [31:0] vert_x_i,
  input  logic signed [31:0] vert_y_i,
  input  logic signed [31:0] vert_z_i,
  input  logic        [31:0] vert_rgba_i,
  input  logic               tex_u_i,
  input  logic               tex_v_i,
  input  logic        [5:0]  slot_i,
  input  logic        [15:0] vert_tiling_i,
  input  logic        [14:0] batch_quads_i,
  input  logic               last_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;
  localparam logic ACT_DRAW    = 1'b0;

  typedef struct {
    logic        kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] rgba;
    logic        u;
    logic        v;
    logic [5:0]  slot;
    logic [15:0] tiling;
    logic [14:0] quads;
    logic        last;
  } vert_word_t;

  vert_word_t  vert_q[$];
  vert_word_t  cause_q[$];
  logic [15:0] slot_tbl [TEX_SLOTS];
  int          slots_used;
  int          quads_in_batch;
  int          fails;

  assign fail_cnt_o = fails;
  assign pending_o  = vert_q.size();

  function automatic longint unsigned quarter_wave(longint unsigned t);
    longint unsigned t2, p1, p2, v;
    t2 = t * t;
    p1 = longint'(POLY_C3) - ((longint'(POLY_C5) * t2) >> 28);
    p2 = longint'(POLY_C1) - ((p1 * t2) >> 28);
    v  = (p2 * t) >> 14;
    v  = (v + 4096) >> 13;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic longint sine_q15(logic [31:0] a);
    logic [1:0]  q;
    logic [13:0] x;
    longint      m;
    q = a[15:14];
    x = a[13:0];
    m = q[0] ? longint'(quarter_wave(16384 - x)) : longint'(quarter_wave(x));
    return q[1] ? -m : m;
  endfunction

  // floor(d / 65536 + 0.5), wrapped to 32 bits
  function automatic logic [31:0] round_q16(longint d);
    longint r;
    r = (d + 32768) >>> 16;
    return r[31:0];
  endfunction

  function automatic void close_batch();
    vert_word_t w;
    if (quads_in_batch != 0) begin
      w = '{kind: KIND_FLUSH, slot: slots_used[5:0], quads: quads_in_batch[14:0],
            default: '0};
      cause_q.push_back(w);
    end
    quads_in_batch = 0;
    slots_used = 0;
  endfunction

  function automatic void predict_quad();
    int          slot;
    bit          hit;
    longint      c, s, sx, sy, hx, hy;
    vert_word_t  w;
    int          cx [4] = '{-1, 1, 1, -1};
    int          cy [4] = '{-1, -1, 1, 1};
    if (quads_in_batch >= MAX_QUADS) close_batch();
    hit = 0;
    slot = 0;
    for (int i = 0; i < slots_used; i++) begin
      if (!hit && slot_tbl[i] == texture_id_i) begin
        hit = 1;
        slot = i;
      end
    end
    if (!hit) begin
      if (slots_used >= TEX_SLOTS) close_batch();
      slot = slots_used;
      slot_tbl[slot] = texture_id_i;
      slots_used++;
    end
    if (angle_i == 0) begin
      c = 32768;
      s = 0;
    end else begin
      c = sine_q15({16'd0, angle_i} + 32'd16384);
      s = sine_q15({16'd0, angle_i});
    end
    sx = longint'(size_x_i);
    sy = longint'(size_y_i);
    for (int k = 0; k < 4; k++) begin
      hx = cx[k] < 0 ? -sx : sx;
      hy = cy[k] < 0 ? -sy : sy;
      w.kind   = KIND_VERTEX;
      w.x      = pos_x_i + round_q16(hx * c - hy * s);
      w.y      = pos_y_i + round_q16(hx * s + hy * c);
      w.z      = pos_z_i;
      w.rgba   = rgba_i;
      w.u      = cx[k] > 0;
      w.v      = cy[k] > 0;
      w.slot   = slot[5:0];
      w.tiling = tiling_i;
      w.quads  = '0;
      w.last   = 1'b0;
      cause_q.push_back(w);
    end
    quads_in_batch++;
  endfunction

  task automatic cmp(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vert_word_t e;
    if (!rst_ni) begin
      slots_used = 0;
      quads_in_batch = 0;
      fails = 0;
      vert_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (vert_q.size() == 0) begin
          $error("unexpected word: kind %0d slot %0d", kind_i, slot_i);
          fails++;
        end else begin
          e = vert_q.pop_front();
          cmp("kind", e.kind, kind_i);
          cmp("vert_x", e.x, $unsigned(vert_x_i));
          cmp("vert_y", e.y, $unsigned(vert_y_i));
          cmp("vert_z", e.z, $unsigned(vert_z_i));
          cmp("vert_rgba", e.rgba, vert_rgba_i);
          cmp("tex_u", e.u, tex_u_i);
          cmp("tex_v", e.v, tex_v_i);
          cmp("slot", e.slot, slot_i);
          cmp("vert_tiling", e.tiling, vert_tiling_i);
          cmp("batch_quads", e.quads, batch_quads_i);
          cmp("last", e.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        cause_q.delete();
        if (action_i == ACT_DRAW) predict_quad();
        else close_batch();
        if (cause_q.size() > 0) cause_q[cause_q.size() - 1].last = 1'b1;
        foreach (cause_q[i]) vert_q.push_back(cause_q[i]);
      end
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam logic ACT_DRAW  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct {
    logic        action;
    logic [31:0] px, py, pz, sx, sy;
    logic [15:0] angle, tex, tiling;
    logic [31:0] rgba;
  } quad_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, size_x = '0, size_y = '0;
  logic        [15:0] angle = '0, texture_id = '0, tiling = '0;
  logic        [31:0] rgba = '0;
  logic               out_valid, out_ready = 1'b0;
  logic               kind, tex_u, tex_v, last;
  logic signed [31:0] vert_x, vert_y, vert_z;
  logic        [31:0] vert_rgba;
  logic        [5:0]  slot;
  logic        [15:0] vert_tiling;
  logic        [14:0] batch_quads;
  int                 fail_cnt, pending;
  bit                 hold_req = 0;
  bit                 no_gaps = 0;
  logic        [15:0] tex_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  textured_quad_batcher u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .size_x_i(size_x), .size_y_i(size_y), .angle_i(angle), .texture_id_i(texture_id),
    .tiling_i(tiling), .rgba_i(rgba), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .kind_o(kind), .vert_x_o(vert_x), .vert_y_o(vert_y), .vert_z_o(vert_z),
    .vert_rgba_o(vert_rgba), .tex_u_o(tex_u), .tex_v_o(tex_v), .slot_o(slot),
    .vert_tiling_o(vert_tiling), .batch_quads_o(batch_quads), .last_o(last)
  );

  tqb_vertex_check u_check (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .action_i(action), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .size_x_i(size_x), .size_y_i(size_y), .angle_i(angle), .texture_id_i(texture_id),
    .tiling_i(tiling), .rgba_i(rgba), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .kind_i(kind), .vert_x_i(vert_x), .vert_y_i(vert_y), .vert_z_i(vert_z),
    .vert_rgba_i(vert_rgba), .tex_u_i(tex_u), .tex_v_i(tex_v), .slot_i(slot),
    .vert_tiling_i(vert_tiling), .batch_quads_i(batch_quads), .last_i(last),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic quad_req_t rand_draw(logic [15:0] tex);
    quad_req_t q;
    q.action = ACT_DRAW;
    q.px = $urandom; q.py = $urandom; q.pz = $urandom;
    q.sx = $urandom; q.sy = $urandom;
    q.angle = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    q.tex = tex;
    q.tiling = $urandom;
    q.rgba = $urandom;
    return q;
  endfunction

  function automatic quad_req_t flush_req();
    quad_req_t q;
    q = rand_draw(16'($urandom));
    q.action = ACT_FLUSH;
    return q;
  endfunction

  task automatic send_word(quad_req_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= q.action;
    pos_x      <= q.px;
    pos_y      <= q.py;
    pos_z      <= q.pz;
    size_x     <= q.sx;
    size_y     <= q.sy;
    angle      <= q.angle;
    texture_id <= q.tex;
    tiling     <= q.tiling;
    rgba       <= q.rgba;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid, hold until the batcher has drained, then let its internal steps settle
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (120) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 60) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    quad_req_t q;
    int        r;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    // directed: empty flush, angle quadrants, field extremes, white texture, hit
    send_word(flush_req());
    foreach (tex_pool[i]) tex_pool[i] = 16'($urandom);
    q = rand_draw(16'd0); q.angle = 16'd0; send_word(q);
    q = rand_draw(16'd0); q.angle = 16'd16384; send_word(q);
    q = rand_draw(16'hFFFF); q.angle = 16'd32768; send_word(q);
    q = rand_draw(16'hFFFF); q.angle = 16'd49152; send_word(q);
    q = rand_draw(16'd1); q.angle = 16'hFFFF; send_word(q);
    q = rand_draw(16'd1);
    q.px = 32'h7FFFFFFF; q.py = 32'h7FFFFFFF; q.pz = 32'h7FFFFFFF;
    q.sx = 32'h7FFFFFFF; q.sy = 32'h7FFFFFFF; q.angle = 16'd8192;
    q.tiling = 16'hFFFF; q.rgba = 32'hFFFFFFFF; send_word(q);
    q = rand_draw(16'd2);
    q.px = 32'h80000000; q.py = 32'h80000000; q.pz = 32'h80000000;
    q.sx = 32'h80000000; q.sy = 32'h80000000; q.angle = 16'd24576;
    q.tiling = 16'h0; q.rgba = 32'h0; send_word(q);
    q = rand_draw(16'd2); q.sx = '0; q.sy = '0; send_word(q);
    send_word(flush_req());
    send_word(flush_req());
    drain();

    // fill every texture slot and spill into a new batch
    for (int i = 0; i < 34; i++) send_word(rand_draw(16'(16'h100 + i)));
    send_word(flush_req());
    drain();

    // long receiver hold-off while draws keep coming
    hold_req = 1;
    for (int i = 0; i < 12; i++) send_word(rand_draw(tex_pool[$urandom_range(0, 7)]));
    drain();

    // random mix: mostly pooled textures, some fresh ids, occasional flushes
    for (int n = 0; n < 360; n++) begin
      if (n % 70 == 0) no_gaps = $urandom_range(0, 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 6) q = flush_req();
      else if (r < 70) q = rand_draw(tex_pool[$urandom_range(0, 7)]);
      else if (r < 80) q = rand_draw(16'($urandom_range(0, 3)));
      else q = rand_draw(16'($urandom));
      send_word(q);
      if (n == 180) drain();
    end
    no_gaps = 0;
    drain();

    wait (pending == 0);
    repeat (120) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS textured_quad_batcher");
    end else begin
      $display("FAIL textured_quad_batcher");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL textured_quad_batcher");
    $finish;
  end

endmodule
